// ===== hw/rtl/pointillist_stamp_painter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// pointillist stamp painter assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef POINTILLIST_STAMP_PAINTER_UNIT_MACROS_SVH
`define POINTILLIST_STAMP_PAINTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PSPU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSPU_ASSERT_IMPL(label, ante, cons)
`define PSPU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/pspu_pkg.sv =====
// ----------------------------------------------------------------------------
// pspu_pkg
// shared types and constants of the pointillist stamp painter
// ----------------------------------------------------------------------------
package pspu_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  localparam int COORD_W    = 12;
  localparam int DIM_W      = COORD_W - 1;

  localparam int PIX_W      = 24;
  localparam logic [PIX_W-1:0] WHITE = {PIX_W{1'b1}};

  localparam int GRID_SIDE  = 11;
  localparam int GRID_HALF  = 5;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W      = $clog2(GRID_CELLS);
  localparam int POS_W      = $clog2(GRID_SIDE);
  localparam int MASK_HI_W  = GRID_CELLS - 64;

  localparam logic [2:0] REG_CANVAS_WIDTH     = 3'd0;
  localparam logic [2:0] REG_CANVAS_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_NORMAL_MASK_LOW  = 3'd2;
  localparam logic [2:0] REG_NORMAL_MASK_HIGH = 3'd3;
  localparam logic [2:0] REG_BOOST_MASK_LOW   = 3'd4;
  localparam logic [2:0] REG_BOOST_MASK_HIGH  = 3'd5;

  localparam logic FUNC_STAMP = 1'b0;
  localparam logic FUNC_FILL  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] src_blue;
    logic [7:0] src_green;
    logic [7:0] src_red;
  } req_t;

  typedef struct packed {
    logic [6:0] painted_count;
    logic [7:0] pix_blue;
    logic [7:0] pix_green;
    logic [7:0] pix_red;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

// ===== hw/rtl/pointillist_stamp_painter_unit.sv =====
// ----------------------------------------------------------------------------
// pointillist_stamp_painter_unit: a stamp transaction after acceptance runs a mean
// step, a boost step per colour channel, a scan over the 121 grid cells that reads
// the canvas for each selected cell inside it, a drain and an output step.
// a fill transaction runs a read, a write and an output step; a new transaction is
// taken only once the last one is done. req_stall stays high while one is busy or
// while a result waits to be loaded, and while the canvas ram is swept to white after reset.
// ----------------------------------------------------------------------------
`include "pointillist_stamp_painter_unit_macros.svh"

module pointillist_stamp_painter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  pspu_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output pspu_pkg::rsp_t      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_MEAN    = 4'd2;
  localparam logic [3:0] S_BOOST   = 4'd3;
  localparam logic [3:0] S_SCAN    = 4'd4;
  localparam logic [3:0] S_DRAIN   = 4'd5;
  localparam logic [3:0] S_FILL_RD = 4'd6;
  localparam logic [3:0] S_FILL_WR = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  localparam int AW = pspu_pkg::ADDR_W;
  localparam int CW = pspu_pkg::COORD_W;
  localparam int DW = pspu_pkg::DIM_W;
  localparam int HW = pspu_pkg::MASK_HI_W;

  logic [3:0]  state;

  logic [8:0]    canvas_width;
  logic [8:0]    canvas_height;
  logic [63:0]   normal_mask_low;
  logic [HW-1:0] normal_mask_high;
  logic [63:0]   boost_mask_low;
  logic [HW-1:0] boost_mask_high;

  pspu_pkg::req_t item;
  logic [7:0]   mean;
  logic [1:0]   ch;
  logic [7:0]   boost_b;
  logic [7:0]   boost_g;
  logic [7:0]   boost_r;
  logic [pspu_pkg::IDX_W-1:0] idx;
  logic [pspu_pkg::POS_W-1:0] col;
  logic [pspu_pkg::POS_W-1:0] row;
  logic [6:0]   count;
  logic [7:0]   pix_b;
  logic [7:0]   pix_g;
  logic [7:0]   pix_r;
  logic [AW-1:0] clr_addr;

  logic          p1_valid;
  logic          p1_boost;
  logic [AW-1:0] p1_addr;
  logic          fill_in;

  pspu_pkg::ram_wr_t wr;
  pspu_pkg::ram_rd_t rd;
  logic [pspu_pkg::PIX_W-1:0] rdata;

  // configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width     <= 9'd256;
      canvas_height    <= 9'd256;
      normal_mask_low  <= '0;
      normal_mask_high <= '0;
      boost_mask_low   <= '0;
      boost_mask_high  <= '0;
    end else if (cfg_we) begin
      case (paddr[5:3])
        pspu_pkg::REG_CANVAS_WIDTH:     canvas_width     <= pwdata[8:0];
        pspu_pkg::REG_CANVAS_HEIGHT:    canvas_height    <= pwdata[8:0];
        pspu_pkg::REG_NORMAL_MASK_LOW:  normal_mask_low  <= pwdata;
        pspu_pkg::REG_NORMAL_MASK_HIGH: normal_mask_high <= pwdata[HW-1:0];
        pspu_pkg::REG_BOOST_MASK_LOW:   boost_mask_low   <= pwdata;
        pspu_pkg::REG_BOOST_MASK_HIGH:  boost_mask_high  <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      pspu_pkg::REG_CANVAS_WIDTH:     prdata = 64'(canvas_width);
      pspu_pkg::REG_CANVAS_HEIGHT:    prdata = 64'(canvas_height);
      pspu_pkg::REG_NORMAL_MASK_LOW:  prdata = normal_mask_low;
      pspu_pkg::REG_NORMAL_MASK_HIGH: prdata = 64'(normal_mask_high);
      pspu_pkg::REG_BOOST_MASK_LOW:   prdata = boost_mask_low;
      pspu_pkg::REG_BOOST_MASK_HIGH:  prdata = 64'(boost_mask_high);
      default:                        prdata = '0;
    endcase
  end

  // effective canvas size
  logic [DW-1:0] eff_w;
  logic [DW-1:0] eff_h;
  assign eff_w = (DW'(canvas_width) > DW'(pspu_pkg::MAX_WIDTH)) ?
                 DW'(pspu_pkg::MAX_WIDTH) : DW'(canvas_width);
  assign eff_h = (DW'(canvas_height) > DW'(pspu_pkg::MAX_HEIGHT)) ?
                 DW'(pspu_pkg::MAX_HEIGHT) : DW'(canvas_height);

  // shared coordinate unit: offset add, bounds compare, address
  logic signed [CW-1:0] off_x;
  logic signed [CW-1:0] off_y;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic                 in_canvas;
  logic [AW-1:0]        cell_addr;

  always_comb begin
    if (state == S_SCAN) begin
      off_x = $signed(CW'(col)) - CW'(pspu_pkg::GRID_HALF);
      off_y = $signed(CW'(row)) - CW'(pspu_pkg::GRID_HALF);
    end else begin
      off_x = '0;
      off_y = '0;
    end
  end

  assign cx = $signed(CW'(item.pos_x)) + off_x;
  assign cy = $signed(CW'(item.pos_y)) + off_y;
  assign in_canvas = !cx[CW-1] && !cy[CW-1] &&
                     (cx[DW-1:0] < eff_w) && (cy[DW-1:0] < eff_h);
  assign cell_addr = AW'(cy[pspu_pkg::Y_W-1:0]) * AW'(pspu_pkg::MAX_WIDTH)
                   + AW'(cx[pspu_pkg::X_W-1:0]);

  // grid mask lookup
  logic [pspu_pkg::GRID_CELLS-1:0] nmask;
  logic [pspu_pkg::GRID_CELLS-1:0] bmask;
  logic nb;
  logic sel;
  assign nmask = {normal_mask_high, normal_mask_low};
  assign bmask = {boost_mask_high, boost_mask_low};
  assign nb    = nmask[idx];
  assign sel   = nb || bmask[idx];

  // shared saturation unit, one channel a cycle
  logic [7:0]       ch_val;
  logic signed [9:0] bv;
  logic [7:0]       bclamp;
  logic [19:0]      mean_prod;

  always_comb begin
    case (ch)
      2'd0:    ch_val = item.src_blue;
      2'd1:    ch_val = item.src_green;
      default: ch_val = item.src_red;
    endcase
  end

  assign bv = $signed({1'b0, ch_val, 1'b0}) - $signed({2'b00, mean});
  assign bclamp = bv[9] ? 8'd0 : (bv[8] ? 8'd255 : bv[7:0]);
  // floor of sum/3 by reciprocal, exact for sums up to 765
  assign mean_prod = (20'(item.src_red) + 20'(item.src_green) + 20'(item.src_blue))
                   * 20'd683;

  logic paint;
  assign paint = p1_valid && (rdata == pspu_pkg::WHITE);

  // ram requests
  always_comb begin
    wr = '0;
    rd = '0;
    case (state)
      S_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = clr_addr;
        wr.data = pspu_pkg::WHITE;
      end
      S_SCAN, S_DRAIN: begin
        if (state == S_SCAN) begin
          rd.re   = sel && in_canvas;
          rd.addr = cell_addr;
        end
        if (paint) begin
          wr.we   = 1'b1;
          wr.addr = p1_addr;
          wr.data = p1_boost ? {boost_r, boost_g, boost_b}
                             : {item.src_red, item.src_green, item.src_blue};
        end
      end
      S_FILL_RD: begin
        rd.re   = in_canvas;
        rd.addr = cell_addr;
      end
      S_FILL_WR: begin
        if (fill_in && (rdata == pspu_pkg::WHITE)) begin
          wr.we   = 1'b1;
          wr.addr = p1_addr;
          wr.data = {item.src_red, item.src_green, item.src_blue};
        end
      end
      default: ;
    endcase
  end

  pspu_canvas_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  assign req_stall = (state != S_IDLE);

  // sequencer
  logic rsp_load;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      p1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      p1_valid <= (state == S_SCAN) && sel && in_canvas;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(pspu_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            state <= (req.func == pspu_pkg::FUNC_FILL) ? S_FILL_RD : S_MEAN;
          end
        end
        S_MEAN:    state <= S_BOOST;
        S_BOOST: begin
          if (ch == 2'd2) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == pspu_pkg::IDX_W'(pspu_pkg::GRID_CELLS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN:   state <= S_DONE;
        S_FILL_RD: state <= S_FILL_WR;
        S_FILL_WR: state <= S_DONE;
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item  <= req;
        count <= '0;
        pix_b <= '0;
        pix_g <= '0;
        pix_r <= '0;
        ch    <= '0;
        idx   <= '0;
        col   <= '0;
        row   <= '0;
      end
      S_MEAN: mean <= mean_prod[18:11];
      S_BOOST: begin
        ch <= ch + 1'b1;
        case (ch)
          2'd0:    boost_b <= bclamp;
          2'd1:    boost_g <= bclamp;
          default: boost_r <= bclamp;
        endcase
      end
      S_SCAN: begin
        idx      <= idx + 1'b1;
        p1_addr  <= cell_addr;
        p1_boost <= !nb;
        if (col == pspu_pkg::POS_W'(pspu_pkg::GRID_SIDE - 1)) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
        if (paint) begin
          count <= count + 1'b1;
        end
      end
      S_DRAIN: begin
        if (paint) begin
          count <= count + 1'b1;
        end
      end
      S_FILL_RD: begin
        fill_in <= in_canvas;
        p1_addr <= cell_addr;
      end
      S_FILL_WR: begin
        if (fill_in) begin
          if (rdata == pspu_pkg::WHITE) begin
            pix_r <= item.src_red;
            pix_g <= item.src_green;
            pix_b <= item.src_blue;
          end else begin
            pix_r <= rdata[23:16];
            pix_g <= rdata[15:8];
            pix_b <= rdata[7:0];
          end
        end
      end
      default: ;
    endcase
    if (rsp_load) begin
      rsp.painted_count <= count;
      rsp.pix_blue      <= pix_b;
      rsp.pix_green     <= pix_g;
      rsp.pix_red       <= pix_r;
    end
  end

  `PSPU_ASSERT_IMPL(a_p1_in_scan, p1_valid, (state == S_SCAN) || (state == S_DRAIN))
  `PSPU_ASSERT_IMPL(a_count_max, state == S_DONE, count <= 7'(pspu_pkg::GRID_CELLS))
  `PSPU_ASSERT_IMPL(a_no_idle_write, state == S_IDLE, !wr.we)
  `PSPU_ASSERT_NEXT(a_scan_end, (state == S_SCAN) && (idx == pspu_pkg::IDX_W'(pspu_pkg::GRID_CELLS - 1)), state == S_DRAIN)
  `PSPU_ASSERT_IMPL(a_clear_quiet, state == S_CLEAR, !rsp_valid && req_stall)

endmodule

// ===== hw/rtl/pspu_canvas_ram.sv =====
// ----------------------------------------------------------------------------
// pspu_canvas_ram
// canvas pixel store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pspu_canvas_ram (
  input  logic                          clk,
  input  pspu_pkg::ram_wr_t             wr,
  input  pspu_pkg::ram_rd_t             rd,
  output logic [pspu_pkg::PIX_W-1:0]    rdata
);

  logic [pspu_pkg::PIX_W-1:0] mem [pspu_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
